### design/assert_macros.svh
// Assertion macros used by the bounded multi-stack buffer controller.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge outside reset.
`define BMS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BMS_ASSERT(label, prop, msg)
`define BMS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### design/bmsb_pkg.sv
// Package for the bounded multi-stack buffer: sizes, codes and shared types.
// Used by bmsb_ctrl, bmsb_datapath and bounded_multi_stack_buffer_top.
package bmsb_pkg;

    localparam int NUM_STACKS = 16;
    localparam int MAX_DEPTH  = 16;
    localparam int VALUE_BITS = 32;

    localparam int KIND_W   = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam int STK_W  = $clog2(NUM_STACKS);
    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int ADDR_W = (NUM_STACKS * MAX_DEPTH > 1) ? $clog2(NUM_STACKS * MAX_DEPTH) : 1;
    localparam int SLOTS  = NUM_STACKS * MAX_DEPTH;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH    = 2'd0,
        KIND_POP     = 2'd1,
        KIND_POP_AT  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } cmd_t;

endpackage

### design/bmsb_ctrl.sv
// Controller state machine of the bounded multi-stack buffer.
// Depends on bmsb_pkg and assert_macros.svh; drives bmsb_datapath through cmd_t.
`include "assert_macros.svh"

module bmsb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output bmsb_pkg::cmd_t cmd
);

    bmsb_pkg::state_t state_reg;
    bmsb_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmsb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bmsb_pkg::S_ACCESS;
                end
            end
            bmsb_pkg::S_ACCESS:
            begin
                state_next = bmsb_pkg::S_FINISH;
            end
            bmsb_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? bmsb_pkg::S_ACCESS : bmsb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmsb_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            bmsb_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            bmsb_pkg::S_ACCESS:
            begin
                cmd.execute = 1'b1;
            end
            bmsb_pkg::S_FINISH:
            begin
                in_ready     = out_free;
                cmd.load_out = out_free;
                cmd.capture  = out_free && in_valid;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmsb_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `BMS_ASSERT(a_load_needs_room, cmd.load_out |-> (!out_valid_reg || out_ready), "result overwritten before it was taken")
    `BMS_ASSERT(a_capture_to_access, cmd.capture |=> (state_reg == bmsb_pkg::S_ACCESS), "captured item not executed next")
    `BMS_ASSERT(a_access_one_cycle, (state_reg == bmsb_pkg::S_ACCESS) |=> (state_reg == bmsb_pkg::S_FINISH), "access phase longer than one cycle")
    `BMS_ASSERT(a_single_load, cmd.load_out |=> (state_reg != bmsb_pkg::S_FINISH), "result loaded but item not retired")

endmodule

### design/bmsb_datapath.sv
// Datapath of the bounded multi-stack buffer: capacity register, fill counts,
// stack search, plate store memory and the result register. Depends on bmsb_pkg.
module bmsb_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bmsb_pkg::cmd_t                 cmd,
    input  logic                           cfg_wr_en,
    input  logic [bmsb_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic [bmsb_pkg::KIND_W-1:0]    kind,
    input  logic [bmsb_pkg::DATA_W-1:0]    push_value,
    input  logic [bmsb_pkg::INDEX_W-1:0]   stack_index,
    output logic [bmsb_pkg::STATUS_W-1:0]  status,
    output logic [bmsb_pkg::DATA_W-1:0]    popped_value
);

    logic [bmsb_pkg::CAP_W-1:0]      cap_reg;
    logic [bmsb_pkg::CMP_W-1:0]      eff_cap;
    logic [bmsb_pkg::CNT_W-1:0]      fill_reg [bmsb_pkg::NUM_STACKS];

    logic                            push_hit;
    logic [bmsb_pkg::STK_W-1:0]      push_stk;
    logic                            pop_hit;
    logic [bmsb_pkg::STK_W-1:0]      pop_stk;
    logic [bmsb_pkg::STK_W-1:0]      at_stk;
    logic                            at_range;

    bmsb_pkg::status_t               sel_status;
    logic [bmsb_pkg::STK_W-1:0]      sel_stk;
    logic                            sel_push;
    logic                            sel_pop;

    bmsb_pkg::status_t               stat_reg;
    logic [bmsb_pkg::STK_W-1:0]      stk_reg;
    logic                            do_push_reg;
    logic                            do_pop_reg;
    logic [bmsb_pkg::VALUE_BITS-1:0] val_reg;

    logic [bmsb_pkg::CNT_W-1:0]      cur_fill;
    logic [bmsb_pkg::CNT_W-1:0]      slot;
    logic [bmsb_pkg::ADDR_W-1:0]     addr;

    logic [bmsb_pkg::VALUE_BITS-1:0] plate_mem [bmsb_pkg::SLOTS];
    logic [bmsb_pkg::VALUE_BITS-1:0] rdata_reg;

    bmsb_pkg::status_t               status_reg;
    logic [bmsb_pkg::DATA_W-1:0]     popped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bmsb_pkg::CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // A capacity of zero acts as one; anything above the stack depth is clipped.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = bmsb_pkg::CMP_W'(1);
        end
        else if (bmsb_pkg::CMP_W'(cap_reg) > bmsb_pkg::CMP_W'(bmsb_pkg::MAX_DEPTH))
        begin
            eff_cap = bmsb_pkg::CMP_W'(bmsb_pkg::MAX_DEPTH);
        end
        else
        begin
            eff_cap = bmsb_pkg::CMP_W'(cap_reg);
        end
    end

    // Leftmost stack that is not full and rightmost stack that is not empty.
    always_comb
    begin
        push_hit = 1'b0;
        push_stk = '0;
        pop_hit  = 1'b0;
        pop_stk  = '0;
        for (int s = bmsb_pkg::NUM_STACKS - 1; s >= 0; s--)
        begin
            if (bmsb_pkg::CMP_W'(fill_reg[s]) < eff_cap)
            begin
                push_hit = 1'b1;
                push_stk = bmsb_pkg::STK_W'(s);
            end
        end
        for (int s = 0; s < bmsb_pkg::NUM_STACKS; s++)
        begin
            if (fill_reg[s] != '0)
            begin
                pop_hit = 1'b1;
                pop_stk = bmsb_pkg::STK_W'(s);
            end
        end
    end

    assign at_stk   = stack_index[bmsb_pkg::STK_W-1:0];
    assign at_range = (9'(stack_index) >= 9'(bmsb_pkg::NUM_STACKS));

    always_comb
    begin
        sel_status = bmsb_pkg::STAT_DONE;
        sel_stk    = '0;
        sel_push   = 1'b0;
        sel_pop    = 1'b0;
        unique case (kind)
            bmsb_pkg::KIND_PUSH:
            begin
                sel_status = push_hit ? bmsb_pkg::STAT_DONE : bmsb_pkg::STAT_FULL;
                sel_stk    = push_stk;
                sel_push   = push_hit;
            end
            bmsb_pkg::KIND_POP:
            begin
                sel_status = pop_hit ? bmsb_pkg::STAT_DONE : bmsb_pkg::STAT_EMPTY;
                sel_stk    = pop_stk;
                sel_pop    = pop_hit;
            end
            bmsb_pkg::KIND_POP_AT:
            begin
                sel_stk = at_stk;
                if (at_range)
                begin
                    sel_status = bmsb_pkg::STAT_RANGE;
                end
                else if (fill_reg[at_stk] == '0)
                begin
                    sel_status = bmsb_pkg::STAT_EMPTY;
                end
                else
                begin
                    sel_pop = 1'b1;
                end
            end
            default:
            begin
                sel_status = bmsb_pkg::STAT_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            do_push_reg <= 1'b0;
            do_pop_reg  <= 1'b0;
        end
        else if (cmd.capture)
        begin
            do_push_reg <= sel_push;
            do_pop_reg  <= sel_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stat_reg <= sel_status;
            stk_reg  <= sel_stk;
            val_reg  <= bmsb_pkg::VALUE_BITS'(push_value);
        end
    end

    assign cur_fill = fill_reg[stk_reg];
    assign slot     = do_push_reg ? cur_fill : cur_fill - bmsb_pkg::CNT_W'(1);
    assign addr     = bmsb_pkg::ADDR_W'(stk_reg) * bmsb_pkg::ADDR_W'(bmsb_pkg::MAX_DEPTH)
                    + bmsb_pkg::ADDR_W'(slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < bmsb_pkg::NUM_STACKS; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else if (cmd.execute)
        begin
            if (do_push_reg)
            begin
                fill_reg[stk_reg] <= cur_fill + bmsb_pkg::CNT_W'(1);
            end
            else if (do_pop_reg)
            begin
                fill_reg[stk_reg] <= cur_fill - bmsb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && do_push_reg)
        begin
            plate_mem[addr] <= val_reg;
        end
        if (cmd.execute && do_pop_reg)
        begin
            rdata_reg <= plate_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= stat_reg;
            popped_reg <= do_pop_reg ? bmsb_pkg::DATA_W'(rdata_reg) : '0;
        end
    end

    assign status       = status_reg;
    assign popped_value = popped_reg;

endmodule

### design/bounded_multi_stack_buffer_top.sv
// Bounded multi-stack buffer: a row of stacks that push to the leftmost stack with room,
// pop from the rightmost stack holding a value, or pop from a named stack, one result per
// item. Each item is captured while the fill counts are searched, then reads or writes the
// single-port plate store, whose registered read data is loaded into the result register
// as the next item is captured. A waiting result holds back both its own load into the result
// register and the start of the next item. Depends on bmsb_pkg, bmsb_ctrl and
// bmsb_datapath.
module bounded_multi_stack_buffer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bmsb_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bmsb_pkg::KIND_W-1:0]    kind,
    input  logic [bmsb_pkg::DATA_W-1:0]    push_value,
    input  logic [bmsb_pkg::INDEX_W-1:0]   stack_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bmsb_pkg::STATUS_W-1:0]  status,
    output logic [bmsb_pkg::DATA_W-1:0]    popped_value
);

    bmsb_pkg::cmd_t cmd;

    bmsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bmsb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .kind         (kind),
        .push_value   (push_value),
        .stack_index  (stack_index),
        .status       (status),
        .popped_value (popped_value)
    );

endmodule
